// File: hw/rtl/atkm_pkg.sv
// Shared types and constants of the AT response keyword matcher.
package atkm_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_TICK  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_MATCH     = 3'd0,
        ST_PARAM     = 3'd1,
        ST_TIMEOUT   = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_REPLY_ERR = 3'd4
    } status_t;

    // Register indexes of the configuration port
    localparam logic CFG_EXPECT_WORD = 1'b0;
    localparam logic CFG_EXPECT_LEN  = 1'b1;

    localparam int CFG_DATA_W = 64;
    localparam int LEN_W      = 4;
    localparam logic [LEN_W-1:0] LEN_RESET = 4'd2;

    // Reply tails, newest byte in the low byte: "ERROR" and "FAIL"
    localparam logic [39:0] TAIL_ERROR = 40'h45_52_52_4F_52;
    localparam logic [31:0] TAIL_FAIL  = 32'h46_41_49_4C;

    typedef struct packed {
        logic err_hit;
        logic key_hit;
    } match_flags_t;

endpackage

// File: hw/rtl/atkm_if.sv
// Valid/ready channels for items and results of the keyword matcher.
interface atkm_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [7:0]  data_byte;
    logic [31:0] wait_ms;

    modport source (output valid, output mode, output data_byte, output wait_ms,
                    input ready);
    modport sink   (input valid, input mode, input data_byte, input wait_ms,
                    output ready);
endinterface

interface atkm_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

// File: hw/rtl/atkm_match.sv
// Suffix compare of the reply window against the error words and the keyword.
module atkm_match
    import atkm_pkg::*;
#(
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic [8*MAX_KEY_CHARS-1:0] win,
    input  logic [CFG_DATA_W-1:0]      expect_word,
    input  logic [LEN_W-1:0]           expect_len,
    output match_flags_t               flags
);

    localparam int KW = $clog2(MAX_KEY_CHARS + 1);

    logic [KW-1:0] len_sat;
    logic [KW-1:0] key_len;

    assign len_sat = (expect_len > LEN_W'(MAX_KEY_CHARS)) ? KW'(MAX_KEY_CHARS)
                                                          : KW'(expect_len);

    // Keyword stops at its first zero character
    always_comb
    begin
        key_len = len_sat;
        for (int i = MAX_KEY_CHARS - 1; i >= 0; i--)
        begin
            if ((KW'(i) < len_sat) && (expect_word[8*i +: 8] == 8'h00))
                key_len = KW'(i);
        end
    end

    always_comb
    begin
        logic ok;
        int   idx;
        flags.err_hit = (win[39:0] == TAIL_ERROR) || (win[31:0] == TAIL_FAIL);
        flags.key_hit = 1'b0;
        for (int n = 0; n <= MAX_KEY_CHARS; n++)
        begin
            ok = 1'b1;
            for (int k = 0; k < MAX_KEY_CHARS; k++)
            begin
                idx = (n + MAX_KEY_CHARS - 1 - k) % MAX_KEY_CHARS;
                if ((k < n) && (win[8*k +: 8] != expect_word[8*idx +: 8]))
                    ok = 1'b0;
            end
            if (key_len == KW'(n))
                flags.key_hit = ok;
        end
    end

endmodule

// File: hw/rtl/at_response_keyword_matcher_top.sv
// Top level of the AT response keyword matcher.
//
//   port     dir   beat payload                      accepted when
//   item     sink  mode, data_byte, wait_ms          item.valid & item.ready
//   result   src   status                            result.valid & result.ready
//   cfg      in    cfg_index, cfg_data               cfg_wr_en
//
// One item per cycle while the result is not stalled; an item's beat loads the input
// register, and from there the session update and suffix compare load the result register.
// The result register frees the input side while a result waits; item.ready
// drops only when the input register holds an item and the result is stalled.
// rst_n clears the session (idle) and loads expect_word 0 and expect_len 2.
module at_response_keyword_matcher_top
    import atkm_pkg::*;
#(
    parameter int BUFFER_BYTES  = 256,
    parameter int MAX_KEY_CHARS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    atkm_item_if.sink             item,
    atkm_result_if.source         result,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W  = $clog2(BUFFER_BYTES);
    localparam int HIST_W = 8 * (MAX_KEY_CHARS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_BYTES - 1);

    logic [CFG_DATA_W-1:0] expect_word_reg;
    logic [LEN_W-1:0]      expect_len_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_mode_reg;
    logic [7:0]  s1_byte_reg;
    logic [31:0] s1_tmo_reg;
    logic        s1_advance;

    logic [HIST_W-1:0] recent_reg, recent_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [31:0]       time_left_reg, time_left_next;
    logic              active_reg, active_next;
    logic              nul_seen_reg, nul_seen_next;

    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic    res_hit;

    logic [8*MAX_KEY_CHARS-1:0] win;
    logic [31:0]                time_dec;
    match_flags_t               flags;

    assign s1_advance = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_advance;

    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_word_reg <= '0;
            expect_len_reg  <= LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_EXPECT_WORD: expect_word_reg <= cfg_data;
                CFG_EXPECT_LEN:  expect_len_reg  <= cfg_data[LEN_W-1:0];
                default:         expect_len_reg  <= expect_len_reg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item.ready)
            s1_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            s1_mode_reg <= item.mode;
            s1_byte_reg <= item.data_byte;
            s1_tmo_reg  <= item.wait_ms;
        end
    end

    assign win      = {recent_reg, s1_byte_reg};
    assign time_dec = (time_left_reg != 32'd0) ? time_left_reg - 32'd1 : 32'd0;

    atkm_match #(
        .MAX_KEY_CHARS(MAX_KEY_CHARS)
    ) u_match (
        .win        (win),
        .expect_word(expect_word_reg),
        .expect_len (expect_len_reg),
        .flags      (flags)
    );

    always_comb
    begin
        recent_next    = recent_reg;
        count_next     = count_reg;
        time_left_next = time_left_reg;
        active_next    = active_reg;
        nul_seen_next  = nul_seen_reg;
        res_hit        = 1'b0;
        status_next    = status_reg;

        if (s1_valid_reg && s1_advance)
        begin
            unique case (mode_t'(s1_mode_reg))
                MODE_START:
                begin
                    recent_next    = '0;
                    count_next     = '0;
                    nul_seen_next  = 1'b0;
                    time_left_next = s1_tmo_reg;
                    active_next    = (s1_tmo_reg != 32'd0);
                    if (s1_tmo_reg == 32'd0)
                    begin
                        res_hit     = 1'b1;
                        status_next = ST_PARAM;
                    end
                end
                MODE_BYTE:
                begin
                    if (active_reg)
                    begin
                        recent_next   = win[HIST_W-1:0];
                        count_next    = count_reg + CNT_W'(1);
                        nul_seen_next = nul_seen_reg || (s1_byte_reg == 8'h00);
                        priority if (count_reg >= CNT_LAST)
                        begin
                            res_hit     = 1'b1;
                            status_next = ST_OVERFLOW;
                        end
                        else if (nul_seen_next)
                        begin
                            res_hit = 1'b0;
                        end
                        else if (flags.err_hit)
                        begin
                            res_hit     = 1'b1;
                            status_next = ST_REPLY_ERR;
                        end
                        else if (flags.key_hit)
                        begin
                            res_hit     = 1'b1;
                            status_next = ST_MATCH;
                        end
                        else
                        begin
                            res_hit = 1'b0;
                        end
                    end
                end
                MODE_TICK:
                begin
                    if (active_reg)
                    begin
                        time_left_next = time_dec;
                        if (time_dec == 32'd0)
                        begin
                            res_hit     = 1'b1;
                            status_next = ST_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                    res_hit = 1'b0;
                end
            endcase

            // Any session-ending result drops the session
            if (res_hit)
            begin
                recent_next    = '0;
                count_next     = '0;
                time_left_next = '0;
                active_next    = 1'b0;
                nul_seen_next  = 1'b0;
            end
        end

        out_valid_next = res_hit || (out_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg    <= '0;
            count_reg     <= '0;
            time_left_reg <= '0;
            active_reg    <= 1'b0;
            nul_seen_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_MATCH;
        end
        else
        begin
            recent_reg    <= recent_next;
            count_reg     <= count_next;
            time_left_reg <= time_left_next;
            active_reg    <= active_next;
            nul_seen_reg  <= nul_seen_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

`ifndef SYNTH
    a_active_has_time: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (time_left_reg != 32'd0))
        else $error("active session with no time left");

    a_idle_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (count_reg == '0 && !nul_seen_reg && recent_reg == '0))
        else $error("idle with session state left over");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LAST)
        else $error("byte count past buffer size");

    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> (s1_valid_reg && $stable(s1_mode_reg)
                                           && $stable(s1_byte_reg)))
        else $error("stalled item lost");
`endif

endmodule
